// ----- hdl/srf_pkg.sv -----
// Package for the sawtooth formant resonator: parameter defaults, register
// indexes, reset values, the microcode word type and the microcode table.
// No dependencies.
`timescale 1ns / 1ps

package srf_pkg;

  localparam int PHASE_BITS_DEF = 24;
  localparam int STATE_BITS_DEF = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_FIRST  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_SECOND = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LEAK_FACTOR  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_SCALE = 3'd4;

  localparam logic        [23:0] PHASE_STEP_RST   = 24'd41847;
  localparam logic signed [17:0] COEFF_FIRST_RST  = 18'sd123900;
  localparam logic signed [16:0] COEFF_SECOND_RST = -17'sd59146;
  localparam logic        [16:0] LEAK_FACTOR_RST  = 17'd64881;
  localparam logic        [14:0] OUTPUT_SCALE_RST = 15'd8192;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SAMPLE = 4'd10;
  localparam logic [STEP_W-1:0] STEP_LAST   = 4'd14;

  typedef enum logic [1:0] {
    MA_C1    = 2'd0,
    MA_C2    = 2'd1,
    MA_SCALE = 2'd2,
    MA_LEAK  = 2'd3
  } mul_a_t;

  typedef enum logic [1:0] {
    MB_DN_LO = 2'd0,
    MB_DN_HI = 2'd1,
    MB_DO_LO = 2'd2,
    MB_DO_HI = 2'd3
  } mul_b_t;

  typedef enum logic [2:0] {
    ACC_HOLD   = 3'd0,
    ACC_HALF   = 3'd1,
    ACC_CLEAR  = 3'd2,
    ACC_ADD    = 3'd3,
    ACC_ADD_SH = 3'd4
  } acc_op_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_RESON  = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_LEAK   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_WAIT_REQ = 2'd1,
    JMP_WAIT_OUT = 2'd2,
    JMP_START    = 2'd3
  } jmp_t;

  typedef struct packed {
    mul_a_t  a_sel;
    mul_b_t  b_sel;
    acc_op_t acc_op;
    act_t    act;
    jmp_t    jmp;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{MA_C1, MB_DN_LO, ACC_HOLD, ACT_NONE, JMP_START};
    case (step)
      4'd0:  w = '{MA_C1,    MB_DN_LO, ACC_HALF,   ACT_NONE,   JMP_WAIT_REQ};
      4'd1:  w = '{MA_C1,    MB_DN_LO, ACC_HOLD,   ACT_NONE,   JMP_NEXT};
      4'd2:  w = '{MA_C1,    MB_DN_HI, ACC_ADD,    ACT_NONE,   JMP_NEXT};
      4'd3:  w = '{MA_C2,    MB_DO_LO, ACC_ADD_SH, ACT_NONE,   JMP_NEXT};
      4'd4:  w = '{MA_C2,    MB_DO_HI, ACC_ADD,    ACT_NONE,   JMP_NEXT};
      4'd5:  w = '{MA_C2,    MB_DO_HI, ACC_ADD_SH, ACT_NONE,   JMP_NEXT};
      4'd6:  w = '{MA_C1,    MB_DN_LO, ACC_CLEAR,  ACT_RESON,  JMP_NEXT};
      4'd7:  w = '{MA_SCALE, MB_DN_LO, ACC_HOLD,   ACT_NONE,   JMP_NEXT};
      4'd8:  w = '{MA_SCALE, MB_DN_HI, ACC_ADD,    ACT_NONE,   JMP_NEXT};
      4'd9:  w = '{MA_SCALE, MB_DN_HI, ACC_ADD_SH, ACT_NONE,   JMP_NEXT};
      4'd10: w = '{MA_LEAK,  MB_DN_LO, ACC_HALF,   ACT_SAMPLE, JMP_WAIT_OUT};
      4'd11: w = '{MA_LEAK,  MB_DN_LO, ACC_HOLD,   ACT_NONE,   JMP_NEXT};
      4'd12: w = '{MA_LEAK,  MB_DN_HI, ACC_ADD,    ACT_NONE,   JMP_NEXT};
      4'd13: w = '{MA_LEAK,  MB_DN_HI, ACC_ADD_SH, ACT_NONE,   JMP_NEXT};
      4'd14: w = '{MA_LEAK,  MB_DN_LO, ACC_HOLD,   ACT_LEAK,   JMP_START};
      default: w = '{MA_C1,  MB_DN_LO, ACC_HOLD,   ACT_NONE,   JMP_START};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/sawtooth_formant_resonator.sv -----
// Sample request: out_valid rises after an accepted strobe once the program
// reaches its sample step, and no new request is taken until the sequencer is
// idle again; a stalled sample holds the sequencer until it is taken.
// One shared 18-bit multiplier, stepped by a microcode table, sets the pace.
// A request whose strobe is low is taken and has no effect.
// Synchronous active-low reset loads the register defaults and clears the phase, delays, step and out_valid.
`timescale 1ns / 1ps

module sawtooth_formant_resonator
  import srf_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int STATE_BITS = STATE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_strobe_req,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [15:0]     out_sample,
  output logic                   out_clipped,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int MB_W   = (STATE_BITS - 16 > 17) ? STATE_BITS - 16 : 17;
  localparam int PROD_W = 18 + MB_W;
  localparam int ACC_W  = STATE_BITS + 19;
  localparam int RW     = STATE_BITS + 4;

  logic        [23:0] phase_step_r;
  logic signed [17:0] coeff_first_r;
  logic signed [16:0] coeff_second_r;
  logic        [16:0] leak_factor_r;
  logic        [14:0] output_scale_r;

  logic [PHASE_BITS-1:0]        phase_acc_r;
  logic signed [STATE_BITS-1:0] delay_new_r, delay_old_r;
  logic signed [ACC_W-1:0]      acc_r, acc_nxt;
  logic signed [PROD_W-1:0]     prod_r;
  logic [STEP_W-1:0]            step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [15:0]           out_sample_r;
  logic                         out_clipped_r;

  ctrl_word_t ctrl;
  logic       fire;
  logic       out_free;

  logic signed [17:0]      a_op;
  logic signed [MB_W-1:0]  b_op;
  logic signed [PROD_W-1:0] mul_w;
  logic signed [ACC_W-1:0]  prod_ext;

  logic [PHASE_BITS+16:0]         saw_ext;
  logic [16:0]                    saw_u;
  logic signed [16:0]             saw;
  logic signed [ACC_W-17:0]       acc_hi;
  logic signed [RW-1:0]           reson_sum;
  logic signed [STATE_BITS-1:0]   reson_sat;
  logic signed [RW-1:0]           leak_ext;
  logic signed [STATE_BITS-1:0]   leak_sat;
  logic signed [RW-1:0]           quot;
  logic signed [15:0]             sample_sat;
  logic                           sample_clip;
  logic signed [STATE_BITS-1:0]   state_max, state_min;

  assign cfg_ready   = 1'b1;
  assign ctrl        = ucode(step_r);
  assign in_stall    = (ctrl.jmp != JMP_WAIT_REQ);
  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_clipped = out_clipped_r;
  assign out_free    = !out_valid_r || !out_stall;

  assign state_max = {1'b0, {(STATE_BITS-1){1'b1}}};
  assign state_min = {1'b1, {(STATE_BITS-1){1'b0}}};

  always_comb begin
    case (ctrl.jmp)
      JMP_WAIT_REQ: fire = in_valid && in_strobe_req;
      JMP_WAIT_OUT: fire = out_free;
      JMP_NEXT:     fire = 1'b1;
      JMP_START:    fire = 1'b1;
      default:      fire = 1'b0;
    endcase
  end

  always_comb begin
    case (ctrl.a_sel)
      MA_C1:    a_op = coeff_first_r;
      MA_C2:    a_op = 18'(coeff_second_r);
      MA_SCALE: a_op = $signed({3'b000, output_scale_r});
      MA_LEAK:  a_op = $signed({1'b0, leak_factor_r});
      default:  a_op = coeff_first_r;
    endcase
    case (ctrl.b_sel)
      MB_DN_LO: b_op = $signed({{(MB_W-16){1'b0}}, delay_new_r[15:0]});
      MB_DN_HI: b_op = MB_W'($signed(delay_new_r[STATE_BITS-1:16]));
      MB_DO_LO: b_op = $signed({{(MB_W-16){1'b0}}, delay_old_r[15:0]});
      MB_DO_HI: b_op = MB_W'($signed(delay_old_r[STATE_BITS-1:16]));
      default:  b_op = '0;
    endcase
  end

  assign mul_w    = a_op * b_op;
  assign prod_ext = ACC_W'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    if (fire) begin
      case (ctrl.acc_op)
        ACC_HALF:   acc_nxt = ACC_W'(32768);
        ACC_CLEAR:  acc_nxt = '0;
        ACC_ADD:    acc_nxt = acc_r + prod_ext;
        ACC_ADD_SH: acc_nxt = acc_r + (prod_ext <<< 16);
        ACC_HOLD:   acc_nxt = acc_r;
        default:    acc_nxt = acc_r;
      endcase
    end
  end

  assign saw_ext = {phase_acc_r, 17'b0};
  assign saw_u   = saw_ext[PHASE_BITS+16:PHASE_BITS];
  assign saw     = $signed({~saw_u[16], saw_u[15:0]});
  assign acc_hi  = acc_r[ACC_W-1:16];

  always_comb begin
    reson_sum = RW'(acc_hi) + RW'(saw);
    if (!(&reson_sum[RW-1:STATE_BITS-1]) && (|reson_sum[RW-1:STATE_BITS-1])) begin
      reson_sat = reson_sum[RW-1] ? state_min : state_max;
    end else begin
      reson_sat = reson_sum[STATE_BITS-1:0];
    end

    leak_ext = RW'(acc_hi);
    if (!(&leak_ext[RW-1:STATE_BITS-1]) && (|leak_ext[RW-1:STATE_BITS-1])) begin
      leak_sat = leak_ext[RW-1] ? state_min : state_max;
    end else begin
      leak_sat = leak_ext[STATE_BITS-1:0];
    end

    // Truncation toward zero: a negative product with a nonzero fraction rounds up.
    quot = RW'(acc_hi) + RW'({1'b0, acc_r[ACC_W-1] && (|acc_r[15:0])});
    if (!(&quot[RW-1:15]) && (|quot[RW-1:15])) begin
      sample_sat  = quot[RW-1] ? 16'sh8000 : 16'sh7fff;
      sample_clip = 1'b1;
    end else begin
      sample_sat  = quot[15:0];
      sample_clip = 1'b0;
    end
  end

  always_comb begin
    step_nxt = step_r;
    if (fire) begin
      step_nxt = (ctrl.jmp == JMP_START) ? STEP_IDLE : step_r + 1'b1;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (fire && ctrl.act == ACT_SAMPLE) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_w;
    acc_r  <= acc_nxt;
    if (fire && ctrl.act == ACT_SAMPLE) begin
      out_sample_r  <= sample_sat;
      out_clipped_r <= sample_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= PHASE_STEP_RST;
      coeff_first_r  <= COEFF_FIRST_RST;
      coeff_second_r <= COEFF_SECOND_RST;
      leak_factor_r  <= LEAK_FACTOR_RST;
      output_scale_r <= OUTPUT_SCALE_RST;
      phase_acc_r    <= '0;
      delay_new_r    <= '0;
      delay_old_r    <= '0;
      step_r         <= STEP_IDLE;
      out_valid_r    <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PHASE_STEP:   phase_step_r   <= cfg_data;
          REG_COEFF_FIRST:  coeff_first_r  <= cfg_data[17:0];
          REG_COEFF_SECOND: coeff_second_r <= cfg_data[16:0];
          REG_LEAK_FACTOR:  leak_factor_r  <= cfg_data[16:0];
          REG_OUTPUT_SCALE: output_scale_r <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (fire) begin
        case (ctrl.act)
          ACT_RESON: begin
            delay_old_r <= delay_new_r;
            delay_new_r <= reson_sat;
          end
          ACT_SAMPLE: phase_acc_r <= phase_acc_r + PHASE_BITS'(phase_step_r);
          ACT_LEAK:   delay_new_r <= leak_sat;
          ACT_NONE:   ;
          default:    ;
        endcase
      end
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_LAST)
    else $error("sequencer step beyond end of program");

  a_start_on_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_strobe_req |=> step_r == STEP_IDLE + 1'b1)
    else $error("strobe request did not start the program");

  a_idle_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_strobe_req |=> $stable(phase_acc_r) && step_r == STEP_IDLE)
    else $error("request without strobe changed state");

  a_valid_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step_r) == STEP_SAMPLE)
    else $error("result raised outside the sample step");

  a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_clipped_r |-> out_sample_r == 16'sh7fff || out_sample_r == 16'sh8000)
    else $error("clip flag on an unsaturated sample");

endmodule
